>>> rtl/core/bsr_pkg.sv
// bsr_pkg: shared constants, register index codes and the register struct
// for the bit segment realigner; no dependencies
`default_nettype none

package bsr_pkg;

   localparam int WORD_BITS            = 32;
   localparam int WORD_SHIFT           = $clog2(WORD_BITS);
   localparam int MAX_DEST_WORDS_DEF   = 64;
   localparam int MAX_SOURCE_WORDS_DEF = 2048;
   localparam int QUEUE_DEPTH_DEF      = 4;

   localparam int OFFSET_W      = 17;
   localparam int DEST_BITS_W   = 12;
   localparam int SOURCE_BITS_W = 17;
   localparam int CSR_DATA_W    = 17;
   localparam int CSR_INDEX_W   = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_BIT_OFFSET  = 2'd0,
      REG_DEST_BITS   = 2'd1,
      REG_SOURCE_BITS = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [OFFSET_W-1:0]      bit_offset;
      logic [DEST_BITS_W-1:0]   dest_bits;
      logic [SOURCE_BITS_W-1:0] source_bits;
   } csr_type;

endpackage

`default_nettype wire

>>> rtl/core/bsr_front.sv
// bsr_front: accepts source words, tracks the source index and the previous
// word, tags each request with its position; uses bsr_pkg
`default_nettype none

module bsr_front #(
   parameter int SW  = 11,
   parameter int SPB = 17
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             restart,
   input  wire logic [SPB-1:0]                   sbits_eff,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [bsr_pkg::WORD_BITS-1:0]    req_source_word,
   input  wire logic                             q_full,
   output logic                                  q_push,
   output logic [2*bsr_pkg::WORD_BITS+SW:0]      q_push_data
);

   localparam int KW = SW + 1 + bsr_pkg::WORD_SHIFT;

   logic [bsr_pkg::WORD_BITS-1:0] carry_ff, carry_in;
   logic [SW-1:0]                 sidx_ff, sidx_in;
   logic [KW-1:0]                 known;
   logic                          complete;
   logic                          accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // first source position past this word
   assign known    = {(SW+1)'({1'b0, sidx_ff}) + (SW+1)'(1), {bsr_pkg::WORD_SHIFT{1'b0}}};
   assign complete = (known >= KW'(sbits_eff));

   assign q_push      = accept;
   assign q_push_data = {req_source_word, carry_ff, sidx_ff, complete};

   always_comb begin
      carry_in = carry_ff;
      sidx_in  = sidx_ff;
      if (restart) begin
         carry_in = '0;
         sidx_in  = '0;
      end else if (accept) begin
         carry_in = req_source_word;
         if (!complete) begin
            sidx_in = sidx_ff + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '0;
         sidx_ff  <= '0;
      end else begin
         carry_ff <= carry_in;
         sidx_ff  <= sidx_in;
      end
   end

   // index stops before it can wrap
   a_no_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && !complete && !restart) |=> (sidx_ff != '0))
      else $error("source index wrapped");

endmodule

`default_nettype wire

>>> rtl/core/bsr_queue.sv
// bsr_queue: small fifo between the front and back ends
// generic width and depth; no package use
`default_nettype none

module bsr_queue #(
   parameter int WIDTH = 76,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             flush,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  valid,
   output logic [WIDTH-1:0]      head_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in;
   logic [AW-1:0]    rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == CW'(DEPTH));
   assign valid     = (cnt_ff != '0);
   assign head_data = mem_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (flush) begin
         wr_in  = '0;
         rd_in  = '0;
         cnt_in = '0;
      end else begin
         if (do_push) begin
            wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
         end
         if (do_push && !do_pop) begin
            cnt_in = cnt_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            cnt_in = cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> rtl/core/bsr_back.sv
// bsr_back: walks destination words against queued source words, funnel
// shift, masking and the response register; uses bsr_pkg
`default_nettype none

module bsr_back #(
   parameter int MAX_DEST_WORDS = 64,
   parameter int SW             = 11,
   parameter int SPB            = 17,
   parameter int PW             = 20
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               restart,
   input  wire logic [bsr_pkg::OFFSET_W-1:0]       restart_offset,
   input  wire bsr_pkg::csr_type                   csr,
   input  wire logic [SPB-1:0]                     sbits_eff,
   input  wire logic                               q_valid,
   input  wire logic [2*bsr_pkg::WORD_BITS+SW:0]   q_data,
   output logic                                    q_pop,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [bsr_pkg::WORD_BITS-1:0]           rsp_dest_word,
   output logic                                    rsp_last_word
);

   localparam int WB   = bsr_pkg::WORD_BITS;
   localparam int WS   = bsr_pkg::WORD_SHIFT;
   localparam int QW   = 2 * WB + SW + 1;
   localparam int DMAX = MAX_DEST_WORDS * WB;
   localparam int DPB  = $clog2(DMAX + 1);
   localparam int CNTW = $clog2(MAX_DEST_WORDS + 1);

   function automatic logic [WS:0] clamp_word(input logic signed [PW-1:0] v);
      logic [WS:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > PW'(WB)) begin
         r = (WS+1)'(WB);
      end else begin
         r = v[WS:0];
      end
      return r;
   endfunction

   logic [DPB-1:0]         dbits_eff;
   logic [CNTW-1:0]        count;
   logic [CNTW-1:0]        d_ff, d_in;
   logic signed [PW-1:0]   pos_ff, pos_in;
   logic signed [PW-1:0]   off_s, end_all, src_s, hi_lim;
   logic signed [PW-1:0]   base_s, known_s, rel;
   logic signed [PW-1:0]   lo_a, lo_c, hi_a, hi_c;
   logic [WS:0]            lo_b, hi_b;
   logic [WB-1:0]          cur, carry;
   logic [SW-1:0]          sidx;
   logic                   complete;
   logic                   done, emit_ok, emit_next, out_free, load, last;
   logic [4*WB-1:0]        wide, shifted;
   logic [6:0]             shamt;
   logic [WB-1:0]          mask, word;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WB-1:0]          rsp_word_ff;
   logic                   rsp_last_ff;

   // segment limits, fixed per configuration
   always_comb begin
      if (32'(csr.dest_bits) > 32'(DMAX)) begin
         dbits_eff = DPB'(DMAX);
      end else begin
         dbits_eff = DPB'(csr.dest_bits);
      end
   end

   assign count   = CNTW'((32'(dbits_eff) + 32'(WB - 1)) >> WS);
   assign off_s   = PW'($signed(csr.bit_offset));
   assign end_all = off_s + $signed(PW'(dbits_eff));
   assign src_s   = $signed(PW'(sbits_eff));
   assign hi_lim  = (src_s < end_all) ? src_s : end_all;

   // head of queue
   assign cur      = q_data[QW-1 -: WB];
   assign carry    = q_data[QW-1-WB -: WB];
   assign sidx     = q_data[SW:1];
   assign complete = q_data[0];

   assign base_s  = $signed(PW'({sidx, {WS{1'b0}}}));
   assign known_s = base_s + PW'(WB);
   assign rel     = pos_ff - base_s + PW'(WB);

   assign done      = (d_ff >= count);
   assign emit_ok   = complete || (rel <= PW'(WB)) || (end_all <= known_s);
   assign emit_next = complete || (rel <= 0) || (end_all <= known_s);
   assign last      = (CNTW'(d_ff + CNTW'(1)) == count);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load      = q_valid && !done && emit_ok && out_free && !restart;
   assign q_pop     = q_valid && (done || !emit_ok || (load && (last || !emit_next)));

   // valid bit range within the word
   assign lo_a = -pos_ff;
   assign lo_c = -rel;
   assign hi_a = hi_lim - pos_ff;
   assign hi_c = PW'(2 * WB) - rel;
   assign lo_b = clamp_word((lo_a > lo_c) ? lo_a : lo_c);
   assign hi_b = clamp_word((hi_a < hi_c) ? hi_a : hi_c);

   // funnel shift over carry and current word
   assign wide    = {{WB{1'b0}}, carry, cur, {WB{1'b0}}};
   assign shamt   = 7'(rel + PW'(WB));
   assign shifted = wide << shamt;

   always_comb begin
      for (int b = 0; b < WB; b++) begin
         mask[WB-1-b] = ((WS+1)'(b) >= lo_b) && ((WS+1)'(b) < hi_b);
      end
   end

   assign word = shifted[4*WB-1 -: WB] & mask;

   always_comb begin
      d_in   = d_ff;
      pos_in = pos_ff;
      if (restart) begin
         d_in   = '0;
         pos_in = PW'($signed(restart_offset));
      end else if (load) begin
         d_in   = d_ff + CNTW'(1);
         pos_in = pos_ff + PW'(WB);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff         <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         d_ff         <= d_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_word_ff <= word;
         rsp_last_ff <= last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dest_word = rsp_word_ff;
   assign rsp_last_word = rsp_last_ff;

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (load && last) |=> (d_ff == count))
      else $error("segment not finished after last word");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !load)
      else $error("held response overwritten");

endmodule

`default_nettype wire

>>> rtl/core/bit_segment_realigner_unit.sv
// bit_segment_realigner_unit: top level, register file and the front end,
// queue and back end; uses bsr_pkg, bsr_front, bsr_queue, bsr_back
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_write_data
//   req     | in        | req_valid / req_ready | req_source_word
//   rsp     | out       | rsp_valid / rsp_ready | rsp_dest_word, rsp_last_word
//
// the back end releases one destination word per cycle, unless rsp_ready holds
// it, from a single response register; a request that frees several words
// (zero-fill at a negative offset or at source end) releases them one after
// another while the queue keeps taking requests
// reset is synchronous: offset 0, length 0, source length 1, no clearing pass
// rsp_ready low holds the response, stalls the back end, fills the queue
// and then drops req_ready; csr_ready is always high
`default_nettype none

module bit_segment_realigner_unit #(
   parameter int MAX_DEST_WORDS   = bsr_pkg::MAX_DEST_WORDS_DEF,
   parameter int MAX_SOURCE_WORDS = bsr_pkg::MAX_SOURCE_WORDS_DEF,
   parameter int QUEUE_DEPTH      = bsr_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // register writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bsr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [bsr_pkg::CSR_DATA_W-1:0]    csr_write_data,
   // source words
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [bsr_pkg::WORD_BITS-1:0]     req_source_word,
   // destination words
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [bsr_pkg::WORD_BITS-1:0]          rsp_dest_word,
   output logic                                   rsp_last_word
);

   localparam int WB   = bsr_pkg::WORD_BITS;
   localparam int SMAX = MAX_SOURCE_WORDS * WB;
   // width of an effective source length
   localparam int SPB  = $clog2(SMAX + 1);
   // source word index width
   localparam int SW   = (MAX_SOURCE_WORDS > 1) ? $clog2(MAX_SOURCE_WORDS) : 1;
   // signed bit position width, room for offset plus segment length
   localparam int PW   = ((SPB > bsr_pkg::OFFSET_W) ? SPB : bsr_pkg::OFFSET_W) + 3;
   localparam int QW   = 2 * WB + SW + 1;

   bsr_pkg::csr_type csr_ff, csr_in;
   logic             restart;
   logic [SPB-1:0]   sbits_eff;

   logic             q_push, q_full, q_pop, q_valid;
   logic [QW-1:0]    q_push_data, q_head;

   assign csr_ready = 1'b1;

   // register writes; any listed register restarts the segment
   always_comb begin
      csr_in  = csr_ff;
      restart = 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bsr_pkg::REG_BIT_OFFSET: begin
               csr_in.bit_offset = csr_write_data[bsr_pkg::OFFSET_W-1:0];
               restart           = 1'b1;
            end
            bsr_pkg::REG_DEST_BITS: begin
               csr_in.dest_bits = csr_write_data[bsr_pkg::DEST_BITS_W-1:0];
               restart          = 1'b1;
            end
            bsr_pkg::REG_SOURCE_BITS: begin
               csr_in.source_bits = csr_write_data[bsr_pkg::SOURCE_BITS_W-1:0];
               restart            = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.bit_offset  <= '0;
         csr_ff.dest_bits   <= '0;
         csr_ff.source_bits <= bsr_pkg::SOURCE_BITS_W'(1);
      end else begin
         csr_ff <= csr_in;
      end
   end

   // source length saturates at the source capacity
   always_comb begin
      if (32'(csr_ff.source_bits) > 32'(SMAX)) begin
         sbits_eff = SPB'(SMAX);
      end else begin
         sbits_eff = SPB'(csr_ff.source_bits);
      end
   end

   bsr_front #(
      .SW  (SW),
      .SPB (SPB)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .restart         (restart),
      .sbits_eff       (sbits_eff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_source_word (req_source_word),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_push_data     (q_push_data)
   );

   bsr_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .flush     (restart),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head_data (q_head)
   );

   // restart takes the offset being written, if any
   bsr_back #(
      .MAX_DEST_WORDS (MAX_DEST_WORDS),
      .SW             (SW),
      .SPB            (SPB),
      .PW             (PW)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .restart        (restart),
      .restart_offset (csr_in.bit_offset),
      .csr            (csr_ff),
      .sbits_eff      (sbits_eff),
      .q_valid        (q_valid),
      .q_data         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_dest_word  (rsp_dest_word),
      .rsp_last_word  (rsp_last_word)
   );

endmodule

`default_nettype wire

>>> sim/testbench.sv
// testbench for bit_segment_realigner_unit: register writes, source word stimulus
// and a self-checking realignment predictor; depends on bsr_pkg and the rtl

module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEST_BIT_LIMIT   = bsr_pkg::MAX_DEST_WORDS_DEF * bsr_pkg::WORD_BITS;
   localparam int SOURCE_BIT_LIMIT = bsr_pkg::MAX_SOURCE_WORDS_DEF * bsr_pkg::WORD_BITS;
   localparam int SETTLE_CYCLES    = 80;    // longest zero-fill burst plus margin
   localparam int HOLD_OFF_CYCLES  = 300;
   localparam int TOTAL_ITEMS      = 370;
   // spare index, not a listed register: a write must change nothing
   localparam logic [bsr_pkg::CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   typedef logic [bsr_pkg::CSR_DATA_W-1:0] csr_data_type;

   typedef struct {
      logic [bsr_pkg::WORD_BITS-1:0] dest_word;
      logic                          last_word;
   } dest_beat_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [bsr_pkg::CSR_INDEX_W-1:0]   csr_index = '0;
   logic [bsr_pkg::CSR_DATA_W-1:0]    csr_write_data = '0;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [bsr_pkg::WORD_BITS-1:0]     req_source_word = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [bsr_pkg::WORD_BITS-1:0]     rsp_dest_word;
   logic                              rsp_last_word;

   // predictor copy of the registers and the segment state
   int                                seg_offset = 0;
   int                                seg_dest_bits = 0;
   int                                seg_source_bits = 1;
   logic [bsr_pkg::WORD_BITS-1:0]     carry_word = '0;
   int                                source_count = 0;
   int                                dest_count = 0;

   logic [bsr_pkg::WORD_BITS-1:0]     source_words_waiting[$];
   dest_beat_type                     dest_words_due[$];
   int                                words_offered = 0;
   int                                words_taken = 0;
   int                                mismatches = 0;

   // idling controls, set per phase by the stimulus block
   bit                                sender_idles = 1'b0;
   bit                                receiver_idles = 1'b0;
   int                                hold_requests = 0;
   int                                hold_served = 0;
   int                                hold_left = 0;

   bit_segment_realigner_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_source_word (req_source_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_dest_word   (rsp_dest_word),
      .rsp_last_word   (rsp_last_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // register write applied to the predictor; listed registers restart the segment
   function automatic void apply_register(logic [bsr_pkg::CSR_INDEX_W-1:0] idx,
                                          logic [bsr_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         bsr_pkg::REG_BIT_OFFSET:
            seg_offset = {{(32-bsr_pkg::OFFSET_W){data[bsr_pkg::OFFSET_W-1]}}, data};
         bsr_pkg::REG_DEST_BITS:
            seg_dest_bits = int'(data[bsr_pkg::DEST_BITS_W-1:0]);
         bsr_pkg::REG_SOURCE_BITS:
            seg_source_bits = int'(data[bsr_pkg::SOURCE_BITS_W-1:0]);
         default:
            return;
      endcase
      carry_word = '0;
      source_count = 0;
      dest_count = 0;
   endfunction

   // destination words freed by one source word, queued in order
   function automatic void realign_source_word(logic [bsr_pkg::WORD_BITS-1:0] cur);
      longint        dbits, sbits, base, known, first, stop, j, q;
      int            count, b;
      bit            complete, waiting;
      dest_beat_type beat;
      dbits = seg_dest_bits > DEST_BIT_LIMIT ? DEST_BIT_LIMIT : seg_dest_bits;
      sbits = seg_source_bits > SOURCE_BIT_LIMIT ? SOURCE_BIT_LIMIT : seg_source_bits;
      count = int'((dbits + bsr_pkg::WORD_BITS - 1) / bsr_pkg::WORD_BITS);
      // segment done: word ignored, state untouched
      if (dest_count >= count)
         return;
      base = longint'(source_count) * bsr_pkg::WORD_BITS;
      known = base + bsr_pkg::WORD_BITS;
      complete = known >= sbits;
      waiting = 1'b0;
      while (dest_count < count && !waiting) begin
         first = longint'(dest_count) * bsr_pkg::WORD_BITS;
         stop = first + bsr_pkg::WORD_BITS;
         if (stop > dbits)
            stop = dbits;
         if (!complete && seg_offset + stop > known) begin
            waiting = 1'b1;
         end else begin
            beat.dest_word = '0;
            for (b = 0; b < bsr_pkg::WORD_BITS; b++) begin
               j = first + b;
               q = seg_offset + j;
               if (j < dbits && q >= 0 && q < sbits) begin
                  if (q >= base && q < known)
                     beat.dest_word[31-b] = cur[31 - int'(q - base)];
                  else if (q >= base - bsr_pkg::WORD_BITS && q < base)
                     beat.dest_word[31-b] =
                        carry_word[31 - int'(q - base + bsr_pkg::WORD_BITS)];
               end
            end
            beat.last_word = (dest_count + 1 == count);
            dest_words_due.push_back(beat);
            dest_count++;
         end
      end
      carry_word = cur;
      if (!complete)
         source_count++;
   endfunction

   // source words needed before the whole segment has come out
   function automatic int words_to_finish(int offset, int dbits, int sbits);
      int reach;
      if (dbits > DEST_BIT_LIMIT)
         dbits = DEST_BIT_LIMIT;
      if (sbits > SOURCE_BIT_LIMIT)
         sbits = SOURCE_BIT_LIMIT;
      reach = offset + dbits;
      if (reach > sbits)
         reach = sbits;
      if (reach <= 0)
         return 1;
      return (reach + bsr_pkg::WORD_BITS - 1) / bsr_pkg::WORD_BITS;
   endfunction

   // request driver: next word from the pending queue once the last one is taken, with random idling
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (words_taken == words_offered) begin
         if (source_words_waiting.size() != 0 &&
             !(sender_idles && $urandom_range(99) < 32)) begin
            req_valid <= 1'b1;
            req_source_word <= source_words_waiting.pop_front();
            words_offered++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response receiver: random idling plus a long hold-off when the stimulus asks for one
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(receiver_idles && $urandom_range(99) < 32);
      end
   end

   // monitor: check responses first, then predict for the request taken at this edge
   always @(posedge clock) begin : monitor
      dest_beat_type due;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (dest_words_due.size() == 0) begin
               $error("unexpected response: dest_word %h last_word %b",
                      rsp_dest_word, rsp_last_word);
               mismatches++;
            end else begin
               due = dest_words_due.pop_front();
               if (rsp_dest_word !== due.dest_word) begin
                  $error("dest_word: expected %h, got %h", due.dest_word, rsp_dest_word);
                  mismatches++;
               end
               if (rsp_last_word !== due.last_word) begin
                  $error("last_word: expected %b, got %b", due.last_word, rsp_last_word);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            realign_source_word(req_source_word);
            words_taken++;
         end
      end
   end

   // one register write; returns at a rising edge
   task automatic write_reg(input logic [bsr_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [bsr_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      apply_register(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int offset, input int dest, input int source);
      write_reg(bsr_pkg::REG_BIT_OFFSET, csr_data_type'(offset));
      write_reg(bsr_pkg::REG_DEST_BITS, csr_data_type'(dest));
      write_reg(bsr_pkg::REG_SOURCE_BITS, csr_data_type'(source));
   endtask

   // random source words, with solid zero and one words mixed in
   task automatic queue_words(input int n);
      int k;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(9))
            0:       source_words_waiting.push_back('0);
            1:       source_words_waiting.push_back('1);
            default: source_words_waiting.push_back($urandom);
         endcase
      end
   endtask

   // wait until every request is taken and every response is in, then settle
   task automatic drain();
      while (source_words_waiting.size() != 0 || words_taken != words_offered ||
             dest_words_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int phase_no, pick, offset, dest, source, need, items;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      sender_idles = 1'b1;
      receiver_idles = 1'b1;

      // reset values: empty segment, nothing comes out
      source_words_waiting.push_back('1);
      source_words_waiting.push_back(32'h8000_0001);
      drain();

      // one aligned word, then a word after the segment is done
      configure(0, 32, 32);
      source_words_waiting.push_back('1);
      source_words_waiting.push_back(32'h1234_5678);
      drain();

      // negative offset, oversized length, empty source: 64 zero words
      configure(-2048, 4095, 0);
      source_words_waiting.push_back('1);
      drain();

      // unaligned offset with a source length past the limit
      configure(5, 70, 131071);
      source_words_waiting.push_back('1);
      source_words_waiting.push_back('0);
      source_words_waiting.push_back(32'hAAAA_AAAA);
      source_words_waiting.push_back(32'h5555_5555);
      drain();

      // segment wholly past a short source
      configure(65535, 100, 40);
      source_words_waiting.push_back('1);
      source_words_waiting.push_back('1);
      drain();

      // junk in the unused length bits, then a spare-index write mid-segment
      configure(3, 'h1F040, 4096);
      source_words_waiting.push_back(32'hF0F0_F0F0);
      drain();
      write_reg(REG_UNUSED, '1);
      source_words_waiting.push_back(32'h0F0F_0F0F);
      source_words_waiting.push_back(32'hDEAD_BEEF);
      source_words_waiting.push_back(32'h7FFF_FFFE);
      drain();

      // small negative offset: a leading zero word comes with the first word
      configure(-40, 128, 200);
      source_words_waiting.push_back(32'hC3C3_C3C3);
      source_words_waiting.push_back(32'h3C3C_3C3C);
      source_words_waiting.push_back('1);
      drain();

      // --- back pressure: receiver holds off while the sender keeps going ---
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      configure(0, 2048, 65536);
      hold_requests++;
      queue_words(70);
      drain();

      // --- random segments until the request budget is used ---
      phase_no = 0;
      while (words_offered < TOTAL_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            // far offset anywhere in the field, short source
            offset = int'($urandom_range(131071)) - 65536;
            dest = $urandom_range(4095);
            source = $urandom_range(400);
         end else begin
            offset = int'($urandom_range(320)) - 64;
            if (pick < 70)
               dest = $urandom_range(256, 1);
            else if (pick < 90)
               dest = $urandom_range(2048, 257);
            else
               dest = $urandom_range(4095, 2049);
            if ($urandom_range(1))
               source = $urandom_range(131071, 4096);
            else
               source = $urandom_range(700);
         end
         need = words_to_finish(offset, dest, source);
         // mostly whole segments, some cut short
         if ($urandom_range(9) == 0)
            items = $urandom_range(need, 1);
         else
            items = need + $urandom_range(3);

         // every sixth phase runs without any idling
         if (phase_no % 6 == 2) begin
            sender_idles = 1'b0;
            receiver_idles = 1'b0;
         end else begin
            sender_idles = $urandom_range(4) != 0;
            receiver_idles = $urandom_range(4) != 0;
         end
         configure(offset, dest, source);
         queue_words(items);
         drain();
         phase_no++;
      end

      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // watchdog
   initial begin
      #4_800_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
